@@ src/dtp_pkg.sv @@
// Shared types, codes and constants of the duration text parser.
package dtp_pkg;

    localparam int VALUE_BITS_DEF = 48;
    localparam int INDEX_BITS_DEF = 16;

    localparam int TOTAL_BITS  = 48;
    localparam int STATUS_BITS = 2;
    localparam int POS_BITS    = 16;
    localparam int CHAR_BITS   = 8;
    localparam int ARG_BITS    = 4;

    localparam int RADIX         = 10;
    localparam int SECS_PER_MIN  = 60;
    localparam int MINS_PER_HOUR = 60;
    localparam int HOURS_PER_DAY = 24;
    localparam int SECS_PER_HOUR = SECS_PER_MIN * MINS_PER_HOUR;
    localparam int SECS_PER_DAY  = SECS_PER_HOUR * HOURS_PER_DAY;
    localparam int MULT_BITS     = $clog2(SECS_PER_DAY + 1);

    localparam logic [CHAR_BITS-1:0] CH_END  = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_MIN  = 8'h6d;
    localparam logic [CHAR_BITS-1:0] CH_HOUR = 8'h68;
    localparam logic [CHAR_BITS-1:0] CH_DAY  = 8'h64;

    localparam logic [1:0] KIND_DIGIT = 2'd0;
    localparam logic [1:0] KIND_UNIT  = 2'd1;
    localparam logic [1:0] KIND_TERM  = 2'd2;

    localparam logic [ARG_BITS-1:0] UNIT_MIN  = 4'd0;
    localparam logic [ARG_BITS-1:0] UNIT_HOUR = 4'd1;
    localparam logic [ARG_BITS-1:0] UNIT_DAY  = 4'd2;

    localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_ILLEGAL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd2;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [ARG_BITS-1:0] arg;
        logic                err;
    } cmd_t;

    localparam int CMD_BITS = $bits(cmd_t);

    typedef struct packed {
        logic [TOTAL_BITS-1:0]  total_seconds;
        logic [STATUS_BITS-1:0] status;
        logic [POS_BITS-1:0]    bad_position;
    } result_t;

    localparam int RESULT_BITS = $bits(result_t);

endpackage

@@ src/duration_text_parser.sv @@
// Top level of the duration text parser: front end, command queue, back end, result queue.
//
// Usage: feed a string such as 12d3h40m15 one character per word on ch, with
// push; a word is taken at a clock edge where push is high and full is low.
// A zero byte ends the string and produces exactly one result word; no other
// character produces one. Results sit on total_seconds, status and
// bad_position while empty is low and are taken at an edge with pop high.
// status is ok, illegal character (total zero, bad_position gives the 1-based
// place of the first bad character) or overflow (total saturated).
// Throughput: one character per cycle while the result queue has room; the limit is the
// single multiply-add on the pending number in the back end, one command a cycle.
// Path: a taken terminator passes the command queue, the term register of the back end
// and the result queue, each registered, before its result appears.
// Stall: while pop stays low the two-entry result queue fills, the back end
// holds terminators, the four-entry command queue fills and full rises.
// Digits still drain into the pending number behind a held terminator; a unit
// waits until the terminator leaves.
// Reset: rst_n clears every count, total, queue and state flag at once (the term
// register's data is not reset); the block takes characters once reset is released.
module duration_text_parser #(
    parameter int VALUE_BITS = dtp_pkg::VALUE_BITS_DEF,
    parameter int INDEX_BITS = dtp_pkg::INDEX_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic [dtp_pkg::CHAR_BITS-1:0]    ch,
    output logic                             full,
    input  logic                             pop,
    output logic                             empty,
    output logic [dtp_pkg::TOTAL_BITS-1:0]   total_seconds,
    output logic [dtp_pkg::STATUS_BITS-1:0]  status,
    output logic [dtp_pkg::POS_BITS-1:0]     bad_position
);

    localparam int MID_BITS = dtp_pkg::CMD_BITS + INDEX_BITS;

    // Command queue between front and back
    logic                mid_push;
    logic [MID_BITS-1:0] mid_wdata;
    logic                mid_full;
    logic                mid_pop;
    logic [MID_BITS-1:0] mid_rdata;
    logic                mid_empty;

    // Result queue toward the receiver
    logic                                out_push;
    dtp_pkg::result_t                    out_word;
    logic                                out_full;
    logic [dtp_pkg::RESULT_BITS-1:0]     out_rdata;
    dtp_pkg::result_t                    res;

    dtp_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .ch       (ch),
        .full     (full),
        .mid_push (mid_push),
        .mid_word (mid_wdata),
        .mid_full (mid_full)
    );

    dtp_fifo #(
        .WIDTH (MID_BITS),
        .DEPTH (dtp_pkg::MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wdata),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    dtp_back #(
        .VALUE_BITS (VALUE_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_word  (mid_rdata),
        .mid_pop   (mid_pop),
        .out_push  (out_push),
        .out_word  (out_word),
        .out_full  (out_full)
    );

    // Hold finished results here until the receiver pops them.
    dtp_fifo #(
        .WIDTH (dtp_pkg::RESULT_BITS),
        .DEPTH (dtp_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_word),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign res           = dtp_pkg::result_t'(out_rdata);
    assign total_seconds = res.total_seconds;
    assign status        = res.status;
    assign bad_position  = res.bad_position;

endmodule

@@ src/dtp_fifo.sv @@
// Small register-based first-in first-out queue.
module dtp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ src/dtp_front.sv @@
// Front end: accept characters, classify them, track position and errors.
module dtp_front #(
    parameter int INDEX_BITS = dtp_pkg::INDEX_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    input  logic [dtp_pkg::CHAR_BITS-1:0]          ch,
    output logic                                   full,
    output logic                                   mid_push,
    output logic [dtp_pkg::CMD_BITS+INDEX_BITS-1:0] mid_word,
    input  logic                                   mid_full
);

    localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

    logic [INDEX_BITS-1:0] char_index_reg, char_index_next;
    logic [INDEX_BITS-1:0] error_index_reg, error_index_next;
    logic                  error_seen_reg, error_seen_next;
    logic [INDEX_BITS-1:0] index_inc;
    logic                  accept;
    logic                  is_end, is_digit, is_unit;
    dtp_pkg::cmd_t         cmd;

    assign full     = mid_full;
    assign accept   = push && !mid_full;
    assign is_end   = (ch == dtp_pkg::CH_END);
    assign is_digit = (ch >= dtp_pkg::CH_ZERO) && (ch <= dtp_pkg::CH_NINE);
    assign is_unit  = (ch == dtp_pkg::CH_MIN) || (ch == dtp_pkg::CH_HOUR)
                   || (ch == dtp_pkg::CH_DAY);
    // Hold the position once it reaches its ceiling.
    assign index_inc = (char_index_reg == INDEX_MAX) ? char_index_reg
                                                     : char_index_reg + 1'b1;

    always_comb
    begin
        cmd.kind = dtp_pkg::KIND_DIGIT;
        cmd.arg  = dtp_pkg::ARG_BITS'(ch - dtp_pkg::CH_ZERO);
        cmd.err  = error_seen_reg;
        priority if (is_end)
        begin
            cmd.kind = dtp_pkg::KIND_TERM;
            cmd.arg  = '0;
        end
        else if (ch == dtp_pkg::CH_MIN)
        begin
            cmd.kind = dtp_pkg::KIND_UNIT;
            cmd.arg  = dtp_pkg::UNIT_MIN;
        end
        else if (ch == dtp_pkg::CH_HOUR)
        begin
            cmd.kind = dtp_pkg::KIND_UNIT;
            cmd.arg  = dtp_pkg::UNIT_HOUR;
        end
        else if (ch == dtp_pkg::CH_DAY)
        begin
            cmd.kind = dtp_pkg::KIND_UNIT;
            cmd.arg  = dtp_pkg::UNIT_DAY;
        end
        else
        begin
            cmd.kind = dtp_pkg::KIND_DIGIT;
        end
    end

    // Forward terminators always, digits and units only before an error; drop everything else.
    assign mid_push = accept && (is_end || (!error_seen_reg && (is_digit || is_unit)));
    assign mid_word = {error_index_reg, cmd};

    always_comb
    begin
        char_index_next  = char_index_reg;
        error_index_next = error_index_reg;
        error_seen_next  = error_seen_reg;
        if (accept)
        begin
            if (is_end)
            begin
                char_index_next  = '0;
                error_index_next = '0;
                error_seen_next  = 1'b0;
            end
            else if (!error_seen_reg)
            begin
                char_index_next = index_inc;
                if (!is_digit && !is_unit)
                begin
                    error_seen_next  = 1'b1;
                    error_index_next = index_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_index_reg  <= '0;
            error_index_reg <= '0;
            error_seen_reg  <= 1'b0;
        end
        else
        begin
            char_index_reg  <= char_index_next;
            error_index_reg <= error_index_next;
            error_seen_reg  <= error_seen_next;
        end
    end

endmodule

@@ src/dtp_back.sv @@
// Back end: build numbers, scale unit terms, accumulate and form results.
module dtp_back #(
    parameter int VALUE_BITS = dtp_pkg::VALUE_BITS_DEF,
    parameter int INDEX_BITS = dtp_pkg::INDEX_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   mid_empty,
    input  logic [dtp_pkg::CMD_BITS+INDEX_BITS-1:0] mid_word,
    output logic                                   mid_pop,
    output logic                                   out_push,
    output dtp_pkg::result_t                       out_word,
    input  logic                                   out_full
);

    localparam int VB = VALUE_BITS;
    localparam int MB = dtp_pkg::MULT_BITS;
    localparam int DW = VB + dtp_pkg::ARG_BITS;
    localparam int PW = VB + MB;
    localparam logic [VB-1:0] VALUE_MAX = '1;

    dtp_pkg::cmd_t         cmd;
    logic [INDEX_BITS-1:0] cmd_pos;

    // Stage A: pending number
    logic [VB-1:0] pending_reg, pending_next;
    logic          ovf_a_reg, ovf_a_next;
    logic [DW-1:0] digit_wide;
    logic          digit_ovf;
    logic [VB-1:0] digit_val;
    logic [MB-1:0] mult;
    logic [PW-1:0] prod_wide;
    logic          prod_ovf;
    logic [VB-1:0] prod_val;
    logic          a_take;

    // Stage B: term register and running total
    logic                  b_valid_reg, b_valid_next;
    logic                  b_is_term_reg;
    logic [VB-1:0]         b_val_reg;
    logic                  b_ovf_reg;
    logic                  b_err_reg;
    logic [INDEX_BITS-1:0] b_pos_reg;
    logic                  b_load;
    logic                  ld_is_term;
    logic [VB-1:0]         ld_val;
    logic                  ld_ovf;
    logic                  b_go, b_free;

    logic [VB-1:0] total_reg, total_next;
    logic          ovf_b_reg, ovf_b_next;
    logic [VB:0]   sum_wide;
    logic          sum_ovf;
    logic [VB-1:0] sum_val;
    logic [63:0]   total_ext;
    logic [31:0]   pos_ext;

    assign cmd     = dtp_pkg::cmd_t'(mid_word[dtp_pkg::CMD_BITS-1:0]);
    assign cmd_pos = mid_word[dtp_pkg::CMD_BITS +: INDEX_BITS];

    // pending * 10 + digit, saturated
    assign digit_wide = (DW'(pending_reg) << 3) + (DW'(pending_reg) << 1) + DW'(cmd.arg);
    assign digit_ovf  = |digit_wide[DW-1:VB];
    assign digit_val  = digit_ovf ? VALUE_MAX : digit_wide[VB-1:0];

    always_comb
    begin
        unique case (cmd.arg)
            dtp_pkg::UNIT_HOUR: mult = MB'(dtp_pkg::SECS_PER_HOUR);
            dtp_pkg::UNIT_DAY:  mult = MB'(dtp_pkg::SECS_PER_DAY);
            default:            mult = MB'(dtp_pkg::SECS_PER_MIN);
        endcase
    end

    assign prod_wide = PW'(pending_reg) * PW'(mult);
    assign prod_ovf  = |prod_wide[PW-1:VB];
    assign prod_val  = prod_ovf ? VALUE_MAX : prod_wide[VB-1:0];

    // Stall only terminators on a full result queue.
    assign b_go    = b_valid_reg && (!b_is_term_reg || !out_full);
    assign b_free  = !b_valid_reg || b_go;
    assign a_take  = !mid_empty && ((cmd.kind == dtp_pkg::KIND_DIGIT) || b_free);
    assign mid_pop = a_take;

    always_comb
    begin
        pending_next = pending_reg;
        ovf_a_next   = ovf_a_reg;
        b_load       = 1'b0;
        ld_is_term   = 1'b0;
        ld_val       = prod_val;
        ld_ovf       = prod_ovf;
        if (a_take)
        begin
            unique case (cmd.kind)
                dtp_pkg::KIND_DIGIT:
                begin
                    pending_next = digit_val;
                    ovf_a_next   = ovf_a_reg || digit_ovf;
                end
                dtp_pkg::KIND_UNIT:
                begin
                    pending_next = '0;
                    b_load       = 1'b1;
                end
                dtp_pkg::KIND_TERM:
                begin
                    pending_next = '0;
                    ovf_a_next   = 1'b0;
                    b_load       = 1'b1;
                    ld_is_term   = 1'b1;
                    ld_val       = pending_reg;
                    ld_ovf       = ovf_a_reg;
                end
                default:
                begin
                    pending_next = pending_reg;
                end
            endcase
        end
        b_valid_next = b_load ? 1'b1 : (b_go ? 1'b0 : b_valid_reg);
    end

    // Stage B: add the term, saturated
    assign sum_wide  = {1'b0, total_reg} + {1'b0, b_val_reg};
    assign sum_ovf   = sum_wide[VB];
    assign sum_val   = sum_ovf ? VALUE_MAX : sum_wide[VB-1:0];
    assign total_ext = 64'(sum_val);
    assign pos_ext   = 32'(b_pos_reg);

    always_comb
    begin
        total_next = total_reg;
        ovf_b_next = ovf_b_reg;
        out_push   = 1'b0;
        if (b_err_reg)
        begin
            out_word.total_seconds = '0;
            out_word.status        = dtp_pkg::STATUS_ILLEGAL;
            out_word.bad_position  = pos_ext[dtp_pkg::POS_BITS-1:0];
        end
        else
        begin
            out_word.total_seconds = total_ext[dtp_pkg::TOTAL_BITS-1:0];
            out_word.status        = (ovf_b_reg || b_ovf_reg || sum_ovf)
                                   ? dtp_pkg::STATUS_OVERFLOW : dtp_pkg::STATUS_OK;
            out_word.bad_position  = '0;
        end
        if (b_go)
        begin
            if (b_is_term_reg)
            begin
                total_next = '0;
                ovf_b_next = 1'b0;
                out_push   = 1'b1;
            end
            else
            begin
                total_next = sum_val;
                ovf_b_next = ovf_b_reg || b_ovf_reg || sum_ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            ovf_a_reg   <= 1'b0;
            b_valid_reg <= 1'b0;
            total_reg   <= '0;
            ovf_b_reg   <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            ovf_a_reg   <= ovf_a_next;
            b_valid_reg <= b_valid_next;
            total_reg   <= total_next;
            ovf_b_reg   <= ovf_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_is_term_reg <= ld_is_term;
            b_val_reg     <= ld_val;
            b_ovf_reg     <= ld_ovf;
            b_err_reg     <= cmd.err;
            b_pos_reg     <= cmd_pos;
        end
    end

    a_pending_clear: assert property (@(posedge clk) disable iff (!rst_n)
        a_take && (cmd.kind != dtp_pkg::KIND_DIGIT) |=> (pending_reg == '0))
        else $error("pending number not cleared after unit or terminator");

    a_digit_sat: assert property (@(posedge clk) disable iff (!rst_n)
        a_take && (cmd.kind == dtp_pkg::KIND_DIGIT) && digit_ovf
        |=> (pending_reg == VALUE_MAX) && ovf_a_reg)
        else $error("pending number overflow not saturated and flagged");

    a_total_clear: assert property (@(posedge clk) disable iff (!rst_n)
        b_go && b_is_term_reg |=> (total_reg == '0) && !ovf_b_reg)
        else $error("running total not cleared after a result");

    a_term_hold: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !b_go |=> b_valid_reg && $stable(b_val_reg))
        else $error("stalled term lost or changed");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result pushed into a full queue");

endmodule
